// File: rtl/core/bdar_pkg.sv
`default_nettype none
package bdar_pkg;

    // Field widths of the poll and event words
    localparam int PIN_W       = 6;
    localparam int TIME_W      = 32;
    localparam int REG_W       = 24;
    localparam int CFG_IDX_W   = 2;

    // Number of debounced buttons; buttons past PIN_W read as held low
    localparam int NUM_BUTTONS = 6;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd2;

    // Register reset values in microseconds
    localparam logic [REG_W-1:0] DEBOUNCE_RST        = 24'd20000;
    localparam logic [REG_W-1:0] REPEAT_START_RST    = 24'd500000;
    localparam logic [REG_W-1:0] REPEAT_INTERVAL_RST = 24'd100000;

    // Timing thresholds shared by all lanes
    typedef struct packed {
        logic [REG_W-1:0] debounce_us;
        logic [REG_W-1:0] repeat_start_us;
        logic [REG_W-1:0] repeat_interval_us;
    } t_cfg;

    // Per-button result of one poll
    typedef struct packed {
        logic down;
        logic press;
        logic repeat_ev;
    } t_lane_ev;

endpackage
`default_nettype wire

// File: rtl/core/bdar_poll_if.sv
`default_nettype none
interface bdar_poll_if;
    logic                         valid;
    logic                         ready;
    logic [bdar_pkg::PIN_W-1:0]   pin_levels;
    logic [bdar_pkg::TIME_W-1:0]  time_now_us;

    modport source (output valid, output pin_levels, output time_now_us, input ready);
    modport sink   (input valid, input pin_levels, input time_now_us, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bdar_event_if.sv
`default_nettype none
interface bdar_event_if;
    logic                         valid;
    logic                         ready;
    logic [bdar_pkg::PIN_W-1:0]   down_mask;
    logic [bdar_pkg::PIN_W-1:0]   pressed_mask;
    logic [bdar_pkg::PIN_W-1:0]   repeat_mask;

    modport source (output valid, output down_mask, output pressed_mask,
                    output repeat_mask, input ready);
    modport sink   (input valid, input down_mask, input pressed_mask,
                    input repeat_mask, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bdar_cfg.sv
`default_nettype none
module bdar_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bdar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bdar_pkg::REG_W-1:0]     i_cfg_data,
    output bdar_pkg::t_cfg                      o_cfg
);
    import bdar_pkg::*;

    t_cfg r_cfg;

    // Hold the thresholds; an unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_us        <= DEBOUNCE_RST;
            r_cfg.repeat_start_us    <= REPEAT_START_RST;
            r_cfg.repeat_interval_us <= REPEAT_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEBOUNCE:        r_cfg.debounce_us        <= i_cfg_data;
                REG_REPEAT_START:    r_cfg.repeat_start_us    <= i_cfg_data;
                REG_REPEAT_INTERVAL: r_cfg.repeat_interval_us <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// File: rtl/core/bdar_lane.sv
`default_nettype none
module bdar_lane (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_key_down,
    input  wire logic [bdar_pkg::TIME_W-1:0] i_now,
    input  wire bdar_pkg::t_cfg              i_cfg,
    output bdar_pkg::t_lane_ev               o_ev
);
    import bdar_pkg::*;

    logic              r_raw, n_raw;
    logic              r_stable, n_stable;
    logic [TIME_W-1:0] r_change, n_change;
    logic [TIME_W-1:0] r_press, n_press;
    logic [TIME_W-1:0] r_repeat, n_repeat;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_repeat;
    logic              settled;
    logic              press_ev;
    logic              repeat_ev;

    // Restart the settle timer on any raw change
    always_comb begin
        n_raw    = i_key_down;
        n_change = (i_key_down != r_raw) ? i_now : r_change;
    end

    // Elapsed times wrap modulo 2^32
    assign since_change = i_now - n_change;
    assign since_press  = i_now - r_press;
    assign since_repeat = i_now - r_repeat;
    assign settled      = since_change >= {{(TIME_W-REG_W){1'b0}}, i_cfg.debounce_us};

    // Accept the settled level, fire press and repeat events
    always_comb begin
        n_stable  = r_stable;
        n_press   = r_press;
        n_repeat  = r_repeat;
        press_ev  = 1'b0;
        repeat_ev = 1'b0;
        if (settled) begin
            if (n_raw != r_stable) begin
                n_stable = n_raw;
                if (n_raw) begin
                    press_ev = 1'b1;
                    n_press  = i_now;
                    n_repeat = i_now;
                end
            end else if (r_stable) begin
                if (since_press >= {{(TIME_W-REG_W){1'b0}}, i_cfg.repeat_start_us} &&
                    since_repeat >= {{(TIME_W-REG_W){1'b0}}, i_cfg.repeat_interval_us}) begin
                    repeat_ev = 1'b1;
                    n_repeat  = i_now;
                end
            end
        end
    end

    // Advance the button state once per processed poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= 1'b0;
            r_stable <= 1'b0;
            r_change <= '0;
            r_press  <= '0;
            r_repeat <= '0;
        end else if (i_en) begin
            r_raw    <= n_raw;
            r_stable <= n_stable;
            r_change <= n_change;
            r_press  <= n_press;
            r_repeat <= n_repeat;
        end
    end

    assign o_ev.down      = n_stable;
    assign o_ev.press     = press_ev;
    assign o_ev.repeat_ev = press_ev | repeat_ev;
endmodule
`default_nettype wire

// File: rtl/core/button_debounce_autorepeat_unit.sv
// Button debouncer with auto-repeat.
// i_poll takes one poll word per handshake: the active-low pin levels of the
// buttons and a wrapping microsecond timestamp. o_event returns one word per
// poll, in order: the debounced down mask, the mask of new presses and the
// mask of presses or auto-repeats.
// A poll is captured in an input register, goes through the per-button
// compare logic and lands in the output register once that one is free,
// which holds its event word valid until the receiver takes it. One poll is
// accepted per cycle while the receiver does not stall; each lane reads and
// writes its button registers in the same cycle, so polls need not wait.
// When the receiver stalls, the output register holds its word and the input
// register holds one more poll; i_poll.ready drops only while both are full
// and o_event.ready is low.
// The thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the block is idle, a rule for the user that the block does not enforce.
// Reset restores the default thresholds, empties both registers and clears
// every button to released with all timestamps at zero.
`default_nettype none
module button_debounce_autorepeat_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bdar_poll_if.sink                           i_poll,
    bdar_event_if.source                        o_event,
    input  wire logic                           i_cfg_we,
    input  wire logic [bdar_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bdar_pkg::REG_W-1:0]     i_cfg_data
);
    import bdar_pkg::*;

    t_cfg                   cfg;
    t_lane_ev               lane_ev [NUM_BUTTONS];
    logic [PIN_W-1:0]       down_w, press_w, repeat_w;

    logic                   r_in_vld;
    logic [PIN_W-1:0]       r_pins;
    logic [TIME_W-1:0]      r_now;
    logic                   r_out_vld;
    logic [PIN_W-1:0]       r_down, r_pressed, r_rep;
    logic                   out_free;
    logic                   advance;

    bdar_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake control of the two registers
    assign out_free     = !r_out_vld || o_event.ready;
    assign advance      = r_in_vld && out_free;
    assign i_poll.ready = !r_in_vld || out_free;

    // Capture the poll word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_poll.ready) begin
            r_in_vld <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_poll.valid && i_poll.ready) begin
            r_pins <= i_poll.pin_levels;
            r_now  <= i_poll.time_now_us;
        end
    end

    // One lane per button; pins past the input width read as held low
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic key_down;
        if (g < PIN_W) begin : g_pin
            assign key_down = !r_pins[g];
        end else begin : g_nopin
            assign key_down = 1'b1;
        end

        bdar_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (advance),
            .i_key_down (key_down),
            .i_now      (r_now),
            .i_cfg      (cfg),
            .o_ev       (lane_ev[g])
        );
    end

    // Gather the masks, keeping only the low output bits
    for (genvar j = 0; j < PIN_W; j++) begin : g_mask
        if (j < NUM_BUTTONS) begin : g_btn
            assign down_w[j]   = lane_ev[j].down;
            assign press_w[j]  = lane_ev[j].press;
            assign repeat_w[j] = lane_ev[j].repeat_ev;
        end else begin : g_nobtn
            assign down_w[j]   = 1'b0;
            assign press_w[j]  = 1'b0;
            assign repeat_w[j] = 1'b0;
        end
    end

    // Hold the event word until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_down    <= down_w;
            r_pressed <= press_w;
            r_rep     <= repeat_w;
        end
    end

    assign o_event.valid        = r_out_vld;
    assign o_event.down_mask    = r_down;
    assign o_event.pressed_mask = r_pressed;
    assign o_event.repeat_mask  = r_rep;
endmodule
`default_nettype wire
